// File: sv/gwsc_pkg.sv
// ============================================================================
// gwsc_pkg
// Shared types and constants of the grid word search counter.
// ============================================================================
package gwsc_pkg;

    localparam int CHAR_W        = 8;
    localparam int PAT_CHARS_W   = 64;
    localparam int PAT_LEN_W     = 4;
    localparam int LINE_WIDTH_W  = 9;
    localparam int ROW_COUNT_W   = 16;
    localparam int FOUND_W       = 4;
    localparam int TOTAL_W       = 24;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 64;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_PATTERN_CHARS  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_LINE_WIDTH     = 2'd2;
    localparam logic [1:0] REG_ROW_COUNT      = 2'd3;

    // Reset values: pattern is the text "XMAS"
    localparam logic [PAT_CHARS_W-1:0]  RST_PATTERN_CHARS  = 64'h0000_0000_5341_4D58;
    localparam logic [PAT_LEN_W-1:0]    RST_PATTERN_LENGTH = 4'd4;
    localparam logic [LINE_WIDTH_W-1:0] RST_LINE_WIDTH     = 9'd140;
    localparam logic [ROW_COUNT_W-1:0]  RST_ROW_COUNT      = 16'd140;

    typedef logic [CHAR_W-1:0] t_char;

    // Characters one cell sees on the back rows: column, diagonal, anti-diagonal
    typedef struct packed {
        t_char ver;
        t_char dia;
        t_char ant;
    } t_line_view;

    // Match flags, forward and reverse reading, per line direction
    typedef struct packed {
        logic hor_f;
        logic hor_r;
        logic ver_f;
        logic ver_r;
        logic dia_f;
        logic dia_r;
        logic ant_f;
        logic ant_r;
    } t_dir_match;

    // Line directions that fit inside the grid for one item
    typedef struct packed {
        logic hor;
        logic ver;
        logic dia;
        logic ant;
    } t_dir_en;

    typedef enum logic [1:0] {
        FS_RUN,
        FS_FILL,
        FS_LAST
    } t_fill_state;

endpackage

// File: sv/gwsc_row_ram.sv
// ============================================================================
// gwsc_row_ram
// One row slot of the line store: one write port, one registered read port.
// ============================================================================
module gwsc_row_ram
    import gwsc_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_char         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_char         o_rd_data
);

    t_char r_mem [DEPTH];
    t_char r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/gwsc_cell.sv
// ============================================================================
// gwsc_cell
// One position of the pattern: row tap plus compare for all eight readings.
// ============================================================================
module gwsc_cell
    import gwsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  t_char      i_char,
    output t_char      o_char,
    input  t_line_view i_view,
    input  t_char      i_pat_fwd,
    input  t_char      i_pat_rev,
    input  logic       i_active,
    input  t_dir_match i_match,
    output t_dir_match o_match
);

    t_char r_tap;

    // Hand the row character on to the next cell
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tap <= i_char;
        end
    end

    assign o_char = r_tap;

    always_comb begin
        o_match = i_match;
        if (i_active) begin
            o_match.hor_f = i_match.hor_f & (r_tap      == i_pat_fwd);
            o_match.hor_r = i_match.hor_r & (r_tap      == i_pat_rev);
            o_match.ver_f = i_match.ver_f & (i_view.ver == i_pat_fwd);
            o_match.ver_r = i_match.ver_r & (i_view.ver == i_pat_rev);
            o_match.dia_f = i_match.dia_f & (i_view.dia == i_pat_fwd);
            o_match.dia_r = i_match.dia_r & (i_view.dia == i_pat_rev);
            o_match.ant_f = i_match.ant_f & (i_view.ant == i_pat_fwd);
            o_match.ant_r = i_match.ant_r & (i_view.ant == i_pat_rev);
        end
    end

endmodule

// File: sv/grid_word_search_counter_core.sv
// ============================================================================
// grid_word_search_counter_core
// An accepted item passes through stage 1 and the output register in that order.
// Throughput: one item per cycle unless an output stall or tap reload holds input; a row
//   of MAX_PATTERN cells and one line store port per slot and direction keep every check
//   in one pass. A row count write that leaves the position past the last row in mid-row
//   stalls input, after stage 1 drains, while the row taps reload from the store.
// Reset (synchronous, active low) clears positions, total and registers; not the line store.
// ============================================================================
module grid_word_search_counter_core
    import gwsc_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_PATTERN = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAR_W-1:0]    i_grid_char,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FOUND_W-1:0]   o_found_here,
    output logic [TOTAL_W-1:0]   o_total_found,
    output logic                 o_grid_done,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;
    localparam int SW = $clog2(MAX_PATTERN);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PAT_CHARS_W-1:0]  r_pattern_chars;
    logic [PAT_LEN_W-1:0]    r_pattern_length;
    logic [LINE_WIDTH_W-1:0] r_line_width;
    logic [ROW_COUNT_W-1:0]  r_row_count;
    logic                    cfg_wr;
    logic [1:0]              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_chars  <= RST_PATTERN_CHARS;
            r_pattern_length <= RST_PATTERN_LENGTH;
            r_line_width     <= RST_LINE_WIDTH;
            r_row_count      <= RST_ROW_COUNT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PATTERN_CHARS:  r_pattern_chars  <= pwdata;
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[PAT_LEN_W-1:0];
                REG_LINE_WIDTH:     r_line_width     <= pwdata[LINE_WIDTH_W-1:0];
                REG_ROW_COUNT:      r_row_count      <= pwdata[ROW_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PATTERN_CHARS:  prdata = r_pattern_chars;
            REG_PATTERN_LENGTH: prdata = PDATA_W'(r_pattern_length);
            REG_LINE_WIDTH:     prdata = PDATA_W'(r_line_width);
            REG_ROW_COUNT:      prdata = PDATA_W'(r_row_count);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes: clamp out-of-range settings into their legal span
    // ------------------------------------------------------------------
    logic [XW-1:0]          w_raw;
    logic [XW-1:0]          w_x;
    logic [XW:0]            w_xx;
    logic [ROW_COUNT_W-1:0] h_eff;
    logic [PAT_LEN_W-1:0]   len_eff;
    logic [PAT_LEN_W-1:0]   lm1;

    assign w_raw = XW'(r_line_width);

    always_comb begin
        if (w_raw == '0) begin
            w_x = XW'(1);
        end else if (w_raw > XW'(MAX_WIDTH)) begin
            w_x = XW'(MAX_WIDTH);
        end else begin
            w_x = w_raw;
        end
        if (r_pattern_length == '0) begin
            len_eff = PAT_LEN_W'(1);
        end else if (r_pattern_length > PAT_LEN_W'(MAX_PATTERN)) begin
            len_eff = PAT_LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = r_pattern_length;
        end
    end

    assign w_xx  = {1'b0, w_x};
    assign h_eff = (r_row_count == '0) ? ROW_COUNT_W'(1) : r_row_count;
    assign lm1   = len_eff - PAT_LEN_W'(1);

    // ------------------------------------------------------------------
    // Grid position and pipeline handshake
    // ------------------------------------------------------------------
    logic [CW-1:0]          r_col_pos, n_col_pos;
    logic [ROW_COUNT_W-1:0] r_row_pos, n_row_pos;
    logic [SW-1:0]          r_slot, n_slot;

    t_fill_state            r_state, n_state;
    logic [SW-1:0]          r_fill_cnt;
    logic                   r_fill_dv;
    logic                   fill_rd;
    logic                   run;
    logic                   fill_start;

    logic                   r_v1;
    logic                   en_out;
    logic                   ld1;
    logic                   accept;

    logic                   wrap_col;
    logic [ROW_COUNT_W:0]   row_tmp;
    logic                   row_zero;
    logic [CW-1:0]          cur_col;
    logic [ROW_COUNT_W-1:0] cur_row;
    logic [SW-1:0]          slot_inc;
    logic [SW-1:0]          cur_slot;
    logic [SW-1:0]          cur_slot_inc;
    logic                   jump_pend;
    logic [XW:0]            col_x;
    logic [XW:0]            lm1_x;
    logic                   last_col;
    logic                   done0;
    t_dir_en                chk0;

    // Step past a column that a narrowed width left behind, then fold the
    // row back to zero if a shorter row count leaves it past the last row.
    assign wrap_col = {1'b0, WW'(r_col_pos)} >= {1'b0, w_x[WW-1:0]};
    assign row_tmp  = wrap_col ? ({1'b0, r_row_pos} + (ROW_COUNT_W+1)'(1))
                               : {1'b0, r_row_pos};
    assign row_zero = row_tmp >= {1'b0, h_eff};
    assign cur_col  = wrap_col ? '0 : r_col_pos;
    assign cur_row  = row_zero ? '0 : row_tmp[ROW_COUNT_W-1:0];
    assign slot_inc = (r_slot == SW'(MAX_PATTERN - 1)) ? '0 : r_slot + SW'(1);
    assign cur_slot = row_zero ? '0 : (wrap_col ? slot_inc : r_slot);
    assign cur_slot_inc = (cur_slot == SW'(MAX_PATTERN - 1)) ? '0 : cur_slot + SW'(1);

    // A mid-row fold to row zero leaves the row taps holding the old row:
    // reload them from slot zero before the next item goes in.
    assign jump_pend = !wrap_col && (r_row_pos >= h_eff) && (r_col_pos != '0);

    assign col_x    = (XW+1)'(cur_col);
    assign lm1_x    = (XW+1)'(lm1);
    assign last_col = (col_x + (XW+1)'(1)) >= w_xx;
    assign done0    = (col_x + (XW+1)'(1) == w_xx) && (cur_row == h_eff - ROW_COUNT_W'(1));

    // Drop any line that would leave the grid
    assign chk0.hor = col_x >= lm1_x;
    assign chk0.ver = cur_row >= ROW_COUNT_W'(lm1);
    assign chk0.dia = chk0.hor & chk0.ver;
    assign chk0.ant = chk0.ver & ((col_x + lm1_x) < w_xx);

    // Stage 1 loads when empty or when its item moves on to the output
    assign en_out     = !o_out_valid || !i_out_stall;
    assign ld1        = !r_v1 || en_out;
    assign o_in_stall = !(run && !jump_pend && ld1);
    assign accept     = i_in_valid && !o_in_stall;
    assign fill_start = run && jump_pend && !r_v1;

    always_comb begin
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        n_slot    = r_slot;
        if (accept) begin
            if (done0) begin
                n_col_pos = '0;
                n_row_pos = '0;
                n_slot    = '0;
            end else if (last_col) begin
                n_col_pos = '0;
                n_row_pos = cur_row + ROW_COUNT_W'(1);
                n_slot    = cur_slot_inc;
            end else begin
                n_col_pos = cur_col + CW'(1);
                n_row_pos = cur_row;
                n_slot    = cur_slot;
            end
        end else if (fill_start) begin
            n_row_pos = '0;
            n_slot    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_slot    <= '0;
        end else begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
            r_slot    <= n_slot;
        end
    end

    // ------------------------------------------------------------------
    // Tap reload sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_RUN:  if (fill_start) n_state = FS_FILL;
            FS_FILL: if (r_fill_cnt == SW'(1)) n_state = FS_LAST;
            FS_LAST: n_state = FS_RUN;
            default: n_state = FS_RUN;
        endcase
    end

    always_comb begin
        case (r_state)
            FS_RUN: begin
                run     = 1'b1;
                fill_rd = 1'b0;
            end
            FS_FILL: begin
                run     = 1'b0;
                fill_rd = 1'b1;
            end
            default: begin
                run     = 1'b0;
                fill_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_RUN;
            r_fill_cnt <= '0;
            r_fill_dv  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill_dv <= fill_rd;
            if (fill_start) begin
                r_fill_cnt <= SW'(MAX_PATTERN - 1);
            end else if (fill_rd) begin
                r_fill_cnt <= r_fill_cnt - SW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one slot per row modulo MAX_PATTERN, three read copies
    // (column, diagonal / tap reload, anti-diagonal)
    // ------------------------------------------------------------------
    t_char ver_q [MAX_PATTERN];
    t_char dia_q [MAX_PATTERN];
    t_char ant_q [MAX_PATTERN];

    for (genvar s = 0; s < MAX_PATTERN; s++) begin : g_slot
        logic [SW:0]   k_sum;
        logic [SW-1:0] k_back;
        logic          wr_en;
        logic          rd_dia;
        logic [CW-1:0] dia_addr;

        // How many rows back this slot lies from the current row
        assign k_sum  = {1'b0, cur_slot} + (SW+1)'(MAX_PATTERN - s);
        assign k_back = (k_sum >= (SW+1)'(MAX_PATTERN))
                      ? SW'(k_sum - (SW+1)'(MAX_PATTERN)) : SW'(k_sum);
        assign wr_en  = accept && (cur_slot == SW'(s));
        assign rd_dia = accept || fill_rd;
        assign dia_addr = fill_rd ? (r_col_pos - CW'(r_fill_cnt))
                                  : (cur_col - CW'(k_back));

        gwsc_row_ram #(
            .DEPTH (MAX_WIDTH),
            .AW    (CW)
        ) u_ver_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (cur_col),
            .i_wr_data (i_grid_char),
            .i_rd_en   (accept),
            .i_rd_addr (cur_col),
            .o_rd_data (ver_q[s])
        );

        gwsc_row_ram #(
            .DEPTH (MAX_WIDTH),
            .AW    (CW)
        ) u_dia_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (cur_col),
            .i_wr_data (i_grid_char),
            .i_rd_en   (rd_dia),
            .i_rd_addr (dia_addr),
            .o_rd_data (dia_q[s])
        );

        gwsc_row_ram #(
            .DEPTH (MAX_WIDTH),
            .AW    (CW)
        ) u_ant_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (cur_col),
            .i_wr_data (i_grid_char),
            .i_rd_en   (accept),
            .i_rd_addr (cur_col + CW'(k_back)),
            .o_rd_data (ant_q[s])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: line checks on the registered store data
    // ------------------------------------------------------------------
    logic [SW-1:0] r_slot1;
    t_dir_en       r_chk1;
    logic          r_done1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ld1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot1 <= cur_slot;
            r_chk1  <= chk0;
            r_done1 <= done0;
        end
    end

    // Row taps shift on each accepted item, or take reloaded characters
    logic       tap_shift;
    t_char      tap_in;
    t_char      tap [MAX_PATTERN];
    t_dir_match chain [MAX_PATTERN+1];

    assign tap_shift = accept || r_fill_dv;
    assign tap_in    = accept ? i_grid_char : dia_q[0];
    assign chain[0]  = '1;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_line_view    view;
        t_char         prev_char;
        logic [SW:0]   p_sum;
        logic [SW-1:0] p_slot;
        logic [2:0]    fwd_idx;
        logic [2:0]    rev_idx;
        logic          active;

        // Physical slot of the row k rows above the item in stage 1
        assign p_sum  = {1'b0, r_slot1} + (SW+1)'(MAX_PATTERN - k);
        assign p_slot = (p_sum >= (SW+1)'(MAX_PATTERN))
                      ? SW'(p_sum - (SW+1)'(MAX_PATTERN)) : SW'(p_sum);

        if (k == 0) begin : g_head
            assign view      = '{ver: tap[0], dia: tap[0], ant: tap[0]};
            assign prev_char = tap_in;
        end else begin : g_body
            assign view      = '{ver: ver_q[p_slot], dia: dia_q[p_slot], ant: ant_q[p_slot]};
            assign prev_char = tap[k-1];
        end

        // Cell k lies k back from the last cell: forward reading compares it
        // with pattern character len-1-k, reverse reading with character k.
        assign active  = PAT_LEN_W'(k) < len_eff;
        assign fwd_idx = 3'(lm1 - PAT_LEN_W'(k));
        assign rev_idx = 3'(k);

        gwsc_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (tap_shift),
            .i_char    (prev_char),
            .o_char    (tap[k]),
            .i_view    (view),
            .i_pat_fwd (r_pattern_chars[CHAR_W*fwd_idx +: CHAR_W]),
            .i_pat_rev (r_pattern_chars[CHAR_W*rev_idx +: CHAR_W]),
            .i_active  (active),
            .i_match   (chain[k]),
            .o_match   (chain[k+1])
        );
    end

    t_dir_match            en_mask;
    logic [FOUND_W-1:0]    found1;
    logic [TOTAL_W:0]      sum_total;
    logic [TOTAL_W-1:0]    n_total;

    assign en_mask = '{hor_f: r_chk1.hor, hor_r: r_chk1.hor,
                       ver_f: r_chk1.ver, ver_r: r_chk1.ver,
                       dia_f: r_chk1.dia, dia_r: r_chk1.dia,
                       ant_f: r_chk1.ant, ant_r: r_chk1.ant};
    assign found1    = FOUND_W'($countones(chain[MAX_PATTERN] & en_mask));
    assign sum_total = {1'b0, o_total_found} + (TOTAL_W+1)'(found1);
    assign n_total   = (sum_total > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                             : sum_total[TOTAL_W-1:0];

    // ------------------------------------------------------------------
    // Output register; the running total advances as each result loads
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid   <= 1'b0;
            o_total_found <= '0;
        end else if (en_out) begin
            o_out_valid <= r_v1;
            if (r_v1) begin
                o_total_found <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v1) begin
            o_found_here <= found1;
            o_grid_done  <= r_done1;
        end
    end

`ifndef SYNTH
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_rd |-> !r_v1)
        else $error("tap reload overlaps an item in stage 1");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_total_found >= $past(o_total_found)))
        else $error("running total went down");

    a_row0_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_pos == '0) |-> (r_slot == '0))
        else $error("row slot out of step with row position");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found_here <= FOUND_W'(8)))
        else $error("more than eight matches on one cell");
`endif

endmodule
